// File: rtl/assert_macros.svh
// Assertion macros shared by the letterbox unmap block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define LBX_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define LBX_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define LBX_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define LBX_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: rtl/lbx_pkg.sv
// Types and constants of the letterbox box unmap block.
package lbx_pkg;

   localparam int COORD_W = 18;
   localparam int NORM_W  = 17;
   localparam int SVAL_W  = 22;
   localparam int NSTAGE  = 8;

   typedef logic [COORD_W-1:0]        coord_type;
   typedef logic [NORM_W-1:0]         norm_type;
   typedef logic signed [SVAL_W-1:0]  sval_type;

   typedef enum logic [2:0] {
      CSR_INV_SCALE   = 3'd0,
      CSR_PAD_X       = 3'd1,
      CSR_PAD_Y       = 3'd2,
      CSR_IMAGE_W     = 3'd3,
      CSR_IMAGE_H     = 3'd4,
      CSR_EXPAND_EN   = 3'd5,
      CSR_MARGIN_FRAC = 3'd6
   } csr_index_type;

   localparam logic [23:0] INV_SCALE_RST = 24'd65536;
   localparam logic [13:0] IMAGE_DIM_RST = 14'd640;
   localparam logic [7:0]  MARGIN_RST    = 8'd102;

endpackage

// File: rtl/letterbox_box_unmap_square_expand.sv
// Letterbox box unmap: normalised box to original-image pixels; margin, squaring optional.
// Eight-stage pipeline taking one box request per clock while the output side keeps up.
// Stages: detector-frame scale, padding subtract, reciprocal-scale multiply (the 27x24
// product per coordinate sets the clock), clamp, margin multiply, side move, square about
// the centre, final clamp. Each stage holds its request while later stages are stalled
// and bubbles close up, so input is refused only when all eight stages are full and the
// output is not taken. The user must write registers through the csr_ port only while
// no request is in flight; the block itself does not enforce this.
`include "assert_macros.svh"

module letterbox_box_unmap_square_expand #(
   parameter int DETECT_SIZE   = 640,
   parameter int MAX_IMAGE_DIM = 8192
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [23:0]       csr_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  lbx_pkg::norm_type req_box_left,
   input  lbx_pkg::norm_type req_box_top,
   input  lbx_pkg::norm_type req_box_right,
   input  lbx_pkg::norm_type req_box_bottom,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lbx_pkg::coord_type rsp_out_left,
   output lbx_pkg::coord_type rsp_out_top,
   output lbx_pkg::coord_type rsp_out_right,
   output lbx_pkg::coord_type rsp_out_bottom
);
   import lbx_pkg::*;

   localparam int DET_W = NORM_W + $clog2(DETECT_SIZE + 1);
   localparam int PAD_W = 26;
   localparam int DIF_W = (DET_W > PAD_W) ? DET_W : PAD_W;
   localparam int PRD_W = DIF_W + 24;
   localparam int R_W   = PRD_W - 28;
   localparam logic [DET_W-1:0] DSIZE = DET_W'(DETECT_SIZE);
   localparam logic [16:0]      MAXD  = 17'(MAX_IMAGE_DIM);

   // configuration
   logic [23:0] inv_scale_ff;
   logic [13:0] pad_x_ff, pad_y_ff, image_w_ff, image_h_ff;
   logic        expand_ff;
   logic [7:0]  margin_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_scale_ff <= INV_SCALE_RST;
         pad_x_ff     <= 14'd0;
         pad_y_ff     <= 14'd0;
         image_w_ff   <= IMAGE_DIM_RST;
         image_h_ff   <= IMAGE_DIM_RST;
         expand_ff    <= 1'b1;
         margin_ff    <= MARGIN_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_INV_SCALE:   inv_scale_ff <= csr_data;
            CSR_PAD_X:       pad_x_ff     <= csr_data[13:0];
            CSR_PAD_Y:       pad_y_ff     <= csr_data[13:0];
            CSR_IMAGE_W:     image_w_ff   <= csr_data[13:0];
            CSR_IMAGE_H:     image_h_ff   <= csr_data[13:0];
            CSR_EXPAND_EN:   expand_ff    <= csr_data[0];
            CSR_MARGIN_FRAC: margin_ff    <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   function automatic coord_type clamp_bound(logic [13:0] dim);
      logic [16:0] d;
      logic [20:0] s;
      d = (17'(dim) > MAXD) ? MAXD : 17'(dim);
      s = {d, 4'b0000};
      return (s > 21'h3FFFF) ? 18'h3FFFF : s[17:0];
   endfunction

   function automatic coord_type clamp_s(sval_type v, coord_type hi);
      sval_type h;
      h = $signed({4'b0000, hi});
      if (v < 0) return '0;
      if (v > h) return hi;
      return v[COORD_W-1:0];
   endfunction

   coord_type lim_w, lim_h;
   assign lim_w = clamp_bound(image_w_ff);
   assign lim_h = clamp_bound(image_h_ff);

   // flow control: a stage loads when empty or when the next one loads
   logic [NSTAGE-1:0] v_ff, v_in, en;

   always_comb begin
      en[NSTAGE-1] = !v_ff[NSTAGE-1] || rsp_ready;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
      v_in[0] = en[0] ? req_valid : v_ff[0];
      for (int k = 1; k < NSTAGE; k++) begin
         v_in[k] = en[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = v_ff[NSTAGE-1];

   // stage 1: detector frame
   logic [DET_W-1:0] s1_det_ff [4];
   logic [DET_W-1:0] s1_det_in [4];
   norm_type         norm [4];

   assign norm[0] = req_box_left;
   assign norm[1] = req_box_top;
   assign norm[2] = req_box_right;
   assign norm[3] = req_box_bottom;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         s1_det_in[i] = DET_W'(norm[i]) * DSIZE;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) s1_det_ff <= s1_det_in;
   end

   // stage 2: padding
   logic [DIF_W-1:0] s2_dif_ff [4];
   logic [DIF_W-1:0] s2_dif_in [4];
   logic [DIF_W-1:0] pad_ext_x, pad_ext_y;

   assign pad_ext_x = DIF_W'({pad_x_ff, 12'h000});
   assign pad_ext_y = DIF_W'({pad_y_ff, 12'h000});

   always_comb begin
      logic [DIF_W-1:0] d, p;
      for (int i = 0; i < 4; i++) begin
         d = DIF_W'(s1_det_ff[i]);
         p = i[0] ? pad_ext_y : pad_ext_x;
         s2_dif_in[i] = (d > p) ? d - p : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) s2_dif_ff <= s2_dif_in;
   end

   // stage 3: reciprocal scale
   logic [R_W-1:0] s3_r_ff [4];
   logic [R_W-1:0] s3_r_in [4];

   always_comb begin
      logic [PRD_W-1:0] prod;
      for (int i = 0; i < 4; i++) begin
         prod = PRD_W'(s2_dif_ff[i]) * PRD_W'(inv_scale_ff);
         s3_r_in[i] = prod[PRD_W-1:28];
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) s3_r_ff <= s3_r_in;
   end

   // stage 4: clamp to image
   coord_type s4_c_ff [4];
   coord_type s4_c_in [4];

   always_comb begin
      coord_type lim;
      for (int i = 0; i < 4; i++) begin
         lim = i[0] ? lim_h : lim_w;
         s4_c_in[i] = (s3_r_ff[i] > R_W'(lim)) ? lim : s3_r_ff[i][COORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) s4_c_ff <= s4_c_in;
   end

   // stage 5: margins
   coord_type s5_c_ff [4];
   sval_type  s5_mw_ff, s5_mh_ff, s5_mw_in, s5_mh_in;

   always_comb begin
      sval_type          fw, fh;
      logic signed [8:0] mf;
      logic signed [30:0] pw, ph;
      fw = $signed({4'b0000, s4_c_ff[2]}) - $signed({4'b0000, s4_c_ff[0]});
      fh = $signed({4'b0000, s4_c_ff[3]}) - $signed({4'b0000, s4_c_ff[1]});
      mf = $signed({1'b0, margin_ff});
      pw = 31'(fw) * 31'(mf);
      ph = 31'(fh) * 31'(mf);
      s5_mw_in = pw[29:8];
      s5_mh_in = ph[29:8];
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s5_c_ff  <= s4_c_ff;
         s5_mw_ff <= s5_mw_in;
         s5_mh_ff <= s5_mh_in;
      end
   end

   // stage 6: move sides out
   coord_type s6_u_ff [4];
   sval_type  s6_e_ff [4];
   sval_type  s6_e_in [4];

   always_comb begin
      s6_e_in[0] = $signed({4'b0000, s5_c_ff[0]}) - s5_mw_ff;
      s6_e_in[1] = $signed({4'b0000, s5_c_ff[1]}) - s5_mh_ff;
      s6_e_in[2] = $signed({4'b0000, s5_c_ff[2]}) + s5_mw_ff;
      s6_e_in[3] = $signed({4'b0000, s5_c_ff[3]}) + s5_mh_ff;
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         s6_u_ff <= s5_c_ff;
         s6_e_ff <= s6_e_in;
      end
   end

   // stage 7: side and doubled centre
   coord_type s7_u_ff [4];
   sval_type  s7_side_ff, s7_cx_ff, s7_cy_ff;
   sval_type  s7_side_in, s7_cx_in, s7_cy_in;

   always_comb begin
      sval_type bw, bh;
      bw = s6_e_ff[2] - s6_e_ff[0];
      bh = s6_e_ff[3] - s6_e_ff[1];
      s7_side_in = (bw > bh) ? bw : bh;
      s7_cx_in   = s6_e_ff[0] + s6_e_ff[2];
      s7_cy_in   = s6_e_ff[1] + s6_e_ff[3];
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         s7_u_ff    <= s6_u_ff;
         s7_side_ff <= s7_side_in;
         s7_cx_ff   <= s7_cx_in;
         s7_cy_ff   <= s7_cy_in;
      end
   end

   // stage 8: square box, final clamp
   coord_type s8_o_ff [4];
   coord_type s8_o_in [4];

   always_comb begin
      sval_type a [4];
      a[0] = (s7_cx_ff - s7_side_ff) >>> 1;
      a[1] = (s7_cy_ff - s7_side_ff) >>> 1;
      a[2] = (s7_cx_ff + s7_side_ff) >>> 1;
      a[3] = (s7_cy_ff + s7_side_ff) >>> 1;
      for (int i = 0; i < 4; i++) begin
         if (expand_ff) begin
            s8_o_in[i] = clamp_s(a[i], i[0] ? lim_h : lim_w);
         end else begin
            s8_o_in[i] = s7_u_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[7]) s8_o_ff <= s8_o_in;
   end

   assign rsp_out_left   = s8_o_ff[0];
   assign rsp_out_top    = s8_o_ff[1];
   assign rsp_out_right  = s8_o_ff[2];
   assign rsp_out_bottom = s8_o_ff[3];

   `LBX_ASSERT_NXT(a_req_enters, clock, reset, req_valid && req_ready, v_ff[0], "request lost at entry")
   `LBX_ASSERT_NXT(a_mid_holds, clock, reset, v_ff[3] && !en[3], v_ff[3], "stalled stage dropped a request")
   `LBX_ASSERT_IMP(a_refuse_full, clock, reset, !req_ready, (&v_ff) && !rsp_ready, "input refused with room in pipeline")

endmodule
